FILE: hdl/cau_pkg.sv
package cau_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MAG_W         = 2 * DATA_WIDTH;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                           kind;
    logic signed [DATA_WIDTH-1:0]  a_re;
    logic signed [DATA_WIDTH-1:0]  a_im;
    logic signed [DATA_WIDTH-1:0]  b_re;
    logic signed [DATA_WIDTH-1:0]  b_im;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  res_re;
    logic signed [DATA_WIDTH-1:0]  res_im;
    status_t                       status;
  } out_t;

  // Control and non-divide results that travel beside the divider cells.
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              dz;
    logic              re_neg;
    logic              im_neg;
    logic [MAG_W-1:0]  re_mag;
    logic [MAG_W-1:0]  im_mag;
  } side_t;

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (DATA_WIDTH - 1));

  // Saturating conversion of sign and magnitude to two's complement.
  function automatic logic [DATA_WIDTH:0] sat_sm(input logic neg, input logic [MAG_W-1:0] mag);
    logic [DATA_WIDTH-1:0] v;
    logic                  f;
    begin
      f = 1'b0;
      if (neg) begin
        if (mag > NEG_LIM) begin
          v = NEG_LIM[DATA_WIDTH-1:0];
          f = 1'b1;
        end else begin
          v = DATA_WIDTH'(~mag[DATA_WIDTH-1:0] + 1'b1);
        end
      end else begin
        if (mag > POS_LIM) begin
          v = POS_LIM[DATA_WIDTH-1:0];
          f = 1'b1;
        end else begin
          v = mag[DATA_WIDTH-1:0];
        end
      end
      sat_sm = {f, v};
    end
  endfunction

endpackage

FILE: hdl/cau_div_cell.sv
module cau_div_cell #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            en,
  input  logic [cau_pkg::MAG_W-1:0]                       den_i,
  input  logic [cau_pkg::MAG_W+FRAC_BITS-1:0]             dvd_i,
  input  logic [cau_pkg::MAG_W-1:0]                       rem_i,
  input  logic [cau_pkg::DATA_WIDTH-1:0]                  q_i,
  input  logic                                            big_i,
  output logic [cau_pkg::MAG_W-1:0]                       den_o,
  output logic [cau_pkg::MAG_W+FRAC_BITS-1:0]             dvd_o,
  output logic [cau_pkg::MAG_W-1:0]                       rem_o,
  output logic [cau_pkg::DATA_WIDTH-1:0]                  q_o,
  output logic                                            big_o
);
  import cau_pkg::*;

  localparam int QW = MAG_W + FRAC_BITS;

  logic [MAG_W-1:0] rsh;
  logic             ge;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign rsh = {rem_i[MAG_W-2:0], dvd_i[QW-1]};
  assign ge  = (rsh >= den_i);

  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= den_i;
      dvd_o <= {dvd_i[QW-2:0], 1'b0};
      rem_o <= ge ? (rsh - den_i) : rsh;
      q_o   <= {q_i[DATA_WIDTH-2:0], ge};
      big_o <= big_i | q_i[DATA_WIDTH-1];
    end
  end

endmodule

FILE: hdl/complex_arith_unit_core.sv
// Complex fixed-point arithmetic unit.
// Input channel in_valid/in_ready carries an in_t: an operation code and two
// complex operands. Result channel out_valid/out_ready carries an out_t: the
// real and imaginary parts, saturated, and a status code.
// Add, subtract, multiply and divide all go down the same pipeline: a
// multiplier stage, a summing stage, a row of 2*DATA_WIDTH+FRAC_BITS divider
// cells in each of the real and imaginary lanes that each settle one quotient
// bit, and a saturating output register.
// One item may be transferred every cycle while no result waits on a low
// out_ready, and results leave in order.
// Reset empties the pipeline; in_ready is high from the first cycle after it.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops until that result is transferred.
module complex_arith_unit_core #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cau_pkg::out_t out_data
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int MW = MAG_W;
  localparam int QW = MW + FRAC_BITS;

  logic en;
  logic out_valid_r;
  out_t out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Multiplier stage.
  logic                  p_valid_r;
  op_t                   p_kind_r;
  logic signed [MW-1:0]  p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_bb_r, p_cc_r;
  logic signed [W:0]     p_are_r, p_aim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_kind_r <= in_data.kind;
      p_rr_r   <= MW'(in_data.a_re) * MW'(in_data.b_re);
      p_ii_r   <= MW'(in_data.a_im) * MW'(in_data.b_im);
      p_ir_r   <= MW'(in_data.a_im) * MW'(in_data.b_re);
      p_ri_r   <= MW'(in_data.a_re) * MW'(in_data.b_im);
      p_bb_r   <= MW'(in_data.b_re) * MW'(in_data.b_re);
      p_cc_r   <= MW'(in_data.b_im) * MW'(in_data.b_im);
      if (in_data.kind == OP_SUB) begin
        p_are_r <= (W+1)'(in_data.a_re) - (W+1)'(in_data.b_re);
        p_aim_r <= (W+1)'(in_data.a_im) - (W+1)'(in_data.b_im);
      end else begin
        p_are_r <= (W+1)'(in_data.a_re) + (W+1)'(in_data.b_re);
        p_aim_r <= (W+1)'(in_data.a_im) + (W+1)'(in_data.b_im);
      end
    end
  end

  // Summing stage.
  function automatic logic [MW:0] to_sm(input logic signed [MW:0] v);
    logic [MW:0] t;
    begin
      t = v[MW] ? (~v + 1'b1) : v;
      to_sm = {v[MW], t[MW-1:0]};
    end
  endfunction

  logic signed [MW:0] s_mre, s_mim, s_dre, s_dim;
  logic [MW:0]        sm_mre, sm_mim, sm_dre, sm_dim, sm_are, sm_aim;
  logic [MW-1:0]      s_den;
  side_t              s_side;

  assign s_mre  = (MW+1)'(p_rr_r) - (MW+1)'(p_ii_r);
  assign s_mim  = (MW+1)'(p_ir_r) + (MW+1)'(p_ri_r);
  assign s_dre  = (MW+1)'(p_rr_r) + (MW+1)'(p_ii_r);
  assign s_dim  = (MW+1)'(p_ir_r) - (MW+1)'(p_ri_r);
  assign sm_mre = to_sm(s_mre);
  assign sm_mim = to_sm(s_mim);
  assign sm_dre = to_sm(s_dre);
  assign sm_dim = to_sm(s_dim);
  assign sm_are = to_sm((MW+1)'(p_are_r));
  assign sm_aim = to_sm((MW+1)'(p_aim_r));
  assign s_den  = MW'($unsigned(p_bb_r)) + MW'($unsigned(p_cc_r));

  always_comb begin
    s_side        = '0;
    s_side.valid  = p_valid_r;
    s_side.is_div = (p_kind_r == OP_DIV);
    s_side.dz     = (p_kind_r == OP_DIV) && (s_den == '0);
    case (p_kind_r)
      OP_MUL: begin
        s_side.re_neg = sm_mre[MW];
        s_side.im_neg = sm_mim[MW];
        s_side.re_mag = sm_mre[MW-1:0] >> FRAC_BITS;
        s_side.im_mag = sm_mim[MW-1:0] >> FRAC_BITS;
      end
      OP_DIV: begin
        s_side.re_neg = sm_dre[MW];
        s_side.im_neg = sm_dim[MW];
      end
      default: begin
        s_side.re_neg = sm_are[MW];
        s_side.im_neg = sm_aim[MW];
        s_side.re_mag = sm_are[MW-1:0];
        s_side.im_mag = sm_aim[MW-1:0];
      end
    endcase
  end

  // Divider row: index 0 is the summing stage register.
  side_t           side_w  [QW+1];
  logic [MW-1:0]   den_re_w[QW+1];
  logic [MW-1:0]   den_im_w[QW+1];
  logic [QW-1:0]   dvd_re_w[QW+1];
  logic [QW-1:0]   dvd_im_w[QW+1];
  logic [MW-1:0]   rem_re_w[QW+1];
  logic [MW-1:0]   rem_im_w[QW+1];
  logic [W-1:0]    q_re_w  [QW+1];
  logic [W-1:0]    q_im_w  [QW+1];
  logic            big_re_w[QW+1];
  logic            big_im_w[QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_w[0] <= '0;
    end else if (en) begin
      side_w[0] <= s_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_re_w[0] <= s_den;
      den_im_w[0] <= s_den;
      dvd_re_w[0] <= QW'(sm_dre[MW-1:0]) << FRAC_BITS;
      dvd_im_w[0] <= QW'(sm_dim[MW-1:0]) << FRAC_BITS;
      rem_re_w[0] <= '0;
      rem_im_w[0] <= '0;
      q_re_w[0]   <= '0;
      q_im_w[0]   <= '0;
      big_re_w[0] <= 1'b0;
      big_im_w[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_w[i+1] <= '0;
      end else if (en) begin
        side_w[i+1] <= side_w[i];
      end
    end

    cau_div_cell #(.FRAC_BITS(FRAC_BITS)) u_re (
      .clk  (clk),
      .en   (en),
      .den_i(den_re_w[i]),
      .dvd_i(dvd_re_w[i]),
      .rem_i(rem_re_w[i]),
      .q_i  (q_re_w[i]),
      .big_i(big_re_w[i]),
      .den_o(den_re_w[i+1]),
      .dvd_o(dvd_re_w[i+1]),
      .rem_o(rem_re_w[i+1]),
      .q_o  (q_re_w[i+1]),
      .big_o(big_re_w[i+1])
    );

    cau_div_cell #(.FRAC_BITS(FRAC_BITS)) u_im (
      .clk  (clk),
      .en   (en),
      .den_i(den_im_w[i]),
      .dvd_i(dvd_im_w[i]),
      .rem_i(rem_im_w[i]),
      .q_i  (q_im_w[i]),
      .big_i(big_im_w[i]),
      .den_o(den_im_w[i+1]),
      .dvd_o(dvd_im_w[i+1]),
      .rem_o(rem_im_w[i+1]),
      .q_o  (q_im_w[i+1]),
      .big_o(big_im_w[i+1])
    );
  end

  // Output stage: pick the lane magnitude and saturate.
  side_t         f_side;
  logic [MW-1:0] f_re_mag, f_im_mag;
  logic [W:0]    f_re, f_im;
  out_t          f_out;

  assign f_side = side_w[QW];

  always_comb begin
    if (f_side.is_div) begin
      f_re_mag = big_re_w[QW] ? '1 : MW'(q_re_w[QW]);
      f_im_mag = big_im_w[QW] ? '1 : MW'(q_im_w[QW]);
    end else begin
      f_re_mag = f_side.re_mag;
      f_im_mag = f_side.im_mag;
    end
    f_re = sat_sm(f_side.re_neg, f_re_mag);
    f_im = sat_sm(f_side.im_neg, f_im_mag);
    if (f_side.dz) begin
      f_out.res_re = '0;
      f_out.res_im = '0;
      f_out.status = ST_DZ;
    end else begin
      f_out.res_re = f_re[W-1:0];
      f_out.res_im = f_im[W-1:0];
      f_out.status = (f_re[W] || f_im[W]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= f_out;
    end
  end

endmodule

FILE: hdl/cau_checker.sv
module cau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input cau_pkg::out_t out_data
);
  import cau_pkg::*;

  localparam logic [DATA_WIDTH-1:0] RMAX = POS_LIM[DATA_WIDTH-1:0];
  localparam logic [DATA_WIDTH-1:0] RMIN = NEG_LIM[DATA_WIDTH-1:0];

  // A stalled result must hold until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input side only stops when a result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled without output back-pressure");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DZ |-> out_data.res_re == '0 && out_data.res_im == '0)
    else $error("divide by zero result not cleared");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_SAT |->
      (out_data.res_re == RMAX || out_data.res_re == RMIN ||
       out_data.res_im == RMAX || out_data.res_im == RMIN))
    else $error("saturation status without a bound value");

  // Nothing leaves the pipeline in the cycle straight after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: bench/complex_arith_unit_core_test.sv
`timescale 1ns / 1ps

module complex_arith_unit_core_test;
  import cau_pkg::*;

  localparam int FB      = FRAC_BITS_DEF;
  localparam int LAT     = 2 * DATA_WIDTH + FB + 3;
  localparam int WD_LIM  = 20000;
  localparam int N_RAND  = 850;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  out_t  out_data;

  complex_arith_unit_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  out_t pending_results[$];
  in_t  stim_q[$];
  out_t fixed_q[$];
  logic fixed_known_q[$];
  int   mismatches;
  int   idle_in_pct;
  int   idle_out_pct;
  logic hold_off;
  logic stim_done;
  int   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturate a sign-magnitude value to the data width.
  function automatic logic signed [DATA_WIDTH-1:0] clamp_sm(
      input logic neg, input longint unsigned mag, inout logic flag);
    longint unsigned m;
    begin
      m = mag;
      if (neg) begin
        if (m > (64'd1 << (DATA_WIDTH - 1))) begin
          m = 64'd1 << (DATA_WIDTH - 1);
          flag = 1'b1;
        end
        return DATA_WIDTH'(-longint'(m));
      end
      if (m > (64'd1 << (DATA_WIDTH - 1)) - 1) begin
        m = (64'd1 << (DATA_WIDTH - 1)) - 1;
        flag = 1'b1;
      end
      return DATA_WIDTH'(m);
    end
  endfunction

  // Scaled quotient, truncated and capped far outside the range.
  function automatic longint unsigned frac_quot(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    longint unsigned cap;
    begin
      cap = 64'd1 << 40;
      q = num / den;
      r = num % den;
      if (q > cap) q = cap;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
        if (q > cap) q = cap;
      end
      return q;
    end
  endfunction

  function automatic out_t complex_result(input in_t x);
    longint ar, ai, br, bi, re, im, den;
    longint unsigned rm, im_m;
    logic flag;
    out_t o;
    begin
      ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im;
      flag = 1'b0;
      case (x.kind)
        OP_ADD: begin re = ar + br; im = ai + bi; end
        OP_SUB: begin re = ar - br; im = ai - bi; end
        OP_MUL: begin
          re = ar * br - ai * bi;
          im = ai * br + ar * bi;
        end
        default: begin
          re = ar * br + ai * bi;
          im = ai * br - ar * bi;
        end
      endcase
      rm   = (re < 0) ? longint'(-re) : longint'(re);
      im_m = (im < 0) ? longint'(-im) : longint'(im);
      if (x.kind == OP_MUL) begin
        // Truncation of the magnitude rounds toward zero.
        rm = rm >> FB;
        im_m = im_m >> FB;
      end else if (x.kind == OP_DIV) begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.res_re = '0;
          o.res_im = '0;
          o.status = ST_DZ;
          return o;
        end
        rm = frac_quot(rm, den);
        im_m = frac_quot(im_m, den);
      end
      o.res_re = clamp_sm(re < 0 && rm != 0, rm, flag);
      o.res_im = clamp_sm(im < 0 && im_m != 0, im_m, flag);
      o.status = flag ? ST_SAT : ST_OK;
      return o;
    end
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] rand_part();
    int sel;
    begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return '0;
        3: return DATA_WIDTH'($urandom_range(0, 1023)) - 16'sd512;
        default: return DATA_WIDTH'($urandom);
      endcase
    end
  endfunction

  task automatic add_row(input op_t k, input int ar, input int ai, input int br,
                         input int bi, input logic known, input int rr,
                         input int ri, input status_t st);
    in_t x;
    out_t o;
    begin
      x.kind = k;
      x.a_re = DATA_WIDTH'(ar); x.a_im = DATA_WIDTH'(ai);
      x.b_re = DATA_WIDTH'(br); x.b_im = DATA_WIDTH'(bi);
      o.res_re = DATA_WIDTH'(rr); o.res_im = DATA_WIDTH'(ri); o.status = st;
      stim_q.push_back(x);
      fixed_q.push_back(o);
      fixed_known_q.push_back(known);
    end
  endtask

  // Sender.
  initial begin
    in_t x;
    out_t o;
    in_valid <= 1'b0;
    in_data <= '0;
    rst_n <= 1'b0;
    stim_done = 1'b0;
    idle_in_pct = 24;
    idle_out_pct = 68;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    add_row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, ST_OK);
    add_row(OP_ADD, 32767, 32767, 1, 1, 1, 32767, 32767, ST_SAT);
    add_row(OP_ADD, -32768, -32768, -1, -1, 1, -32768, -32768, ST_SAT);
    add_row(OP_SUB, -32768, 32767, 1, -1, 1, -32768, 32767, ST_SAT);
    add_row(OP_SUB, 32767, -32768, 32767, -32768, 1, 0, 0, ST_OK);
    add_row(OP_MUL, 256, 0, 256, 0, 1, 256, 0, ST_OK);
    add_row(OP_MUL, -32768, -32768, -32768, -32768, 0, 0, 0, ST_OK);
    add_row(OP_MUL, 32767, 32767, 32767, -32768, 0, 0, 0, ST_OK);
    add_row(OP_MUL, -1, 0, 1, 0, 0, 0, 0, ST_OK);
    add_row(OP_MUL, 300, -700, -123, 45, 0, 0, 0, ST_OK);
    add_row(OP_DIV, 1234, -77, 0, 0, 1, 0, 0, ST_DZ);
    add_row(OP_DIV, -32768, -32768, 0, 0, 1, 0, 0, ST_DZ);
    add_row(OP_DIV, 256, 0, 256, 0, 1, 256, 0, ST_OK);
    add_row(OP_DIV, 32767, -32768, 1, 0, 0, 0, 0, ST_OK);
    add_row(OP_DIV, -32768, 32767, -32768, -32768, 0, 0, 0, ST_OK);
    add_row(OP_DIV, -5, 3, 32767, 1, 0, 0, 0, ST_OK);
    add_row(OP_DIV, 100, 200, -1, 0, 0, 0, 0, ST_OK);
    add_row(OP_DIV, 700, -300, 40, -90, 0, 0, 0, ST_OK);

    for (int n = 0; n < N_RAND; n++) begin
      x.kind = op_t'($urandom_range(0, 3));
      x.a_re = rand_part(); x.a_im = rand_part();
      x.b_re = rand_part(); x.b_im = rand_part();
      if (x.kind == OP_DIV && $urandom_range(0, 19) == 0) begin
        x.b_re = '0; x.b_im = '0;
      end
      stim_q.push_back(x);
      fixed_q.push_back('0);
      fixed_known_q.push_back(1'b0);
    end

    for (int n = 0; n < stim_q.size(); n++) begin
      if (n == 300) begin
        idle_in_pct = 68;
        idle_out_pct = 24;
      end else if (n == 600) begin
        idle_in_pct = 0;
        idle_out_pct = 0;
      end
      while ($urandom_range(0, 99) < idle_in_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_data <= stim_q[n];
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      o = complex_result(stim_q[n]);
      if (fixed_known_q[n] && o !== fixed_q[n])
        $display("table row %0d disagrees with prediction", n);
      pending_results.push_back(fixed_known_q[n] ? fixed_q[n] : o);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver, with one long hold-off so that the pipeline fills.
  initial begin
    out_ready <= 1'b0;
    hold_off = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_off && pending_results.size() >= 40 && idle_out_pct == 0) begin
        hold_off = 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= idle_out_pct);
    end
  end

  // Result checker and watchdog.
  initial begin
    out_t want;
    mismatches = 0;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WD_LIM) begin
        $display("== FAIL ==");
        $finish;
      end
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result transfer with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (out_data.res_re !== want.res_re || out_data.res_im !== want.res_im ||
              out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected re %0d im %0d st %0d, got re %0d im %0d st %0d",
                       want.res_re, want.res_im, want.status,
                       out_data.res_re, out_data.res_im, out_data.status);
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done === 1'b1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
